@@ design/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared constants, action codes and pipeline side-band types.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Raw word width and default number of fraction bits.
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned ACTION_W      = 4;

  // Action codes carried in the action field.
  typedef enum logic [ACTION_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9
  } fpa_op_e;

  // Per-item data that travels alongside the divider stages.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   simple_res;
    logic                is_less;
    logic                is_equal;
    logic                is_greater;
    logic                neg;
    logic                dz;
  } fpa_side_t;

endpackage

`default_nettype wire

@@ design/fpa_if.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU channel interfaces
// Valid/ready channels for the operation input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [fpa_pkg::ACTION_W-1:0]          action;
  logic signed [fpa_pkg::WORD_W-1:0]     operand_a;
  logic signed [fpa_pkg::WORD_W-1:0]     operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fpa_pkg::WORD_W-1:0] result;
  logic                              is_less;
  logic                              is_equal;
  logic                              is_greater;
  logic                              divide_by_zero;

  modport source (output valid, result, is_less, is_equal, is_greater, divide_by_zero,
                  input ready);
  modport sink   (input valid, result, is_less, is_equal, is_greater, divide_by_zero,
                  output ready);
endinterface

`default_nettype wire

@@ design/fpa_mul.sv @@
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Two-stage unsigned magnitude multiply with round half up at the fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_mul #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [fpa_pkg::WORD_W-1:0]  mag_a_i,
  input  wire logic [fpa_pkg::WORD_W-1:0]  mag_b_i,
  output logic      [fpa_pkg::WORD_W-1:0]  mag_o
);

  localparam int unsigned PW = 2 * fpa_pkg::WORD_W;

  logic [PW-1:0]             prod_q;
  logic [PW-1:0]             sum;
  logic [fpa_pkg::WORD_W-1:0] rnd_d, rnd_q;

  // Rounding adds half an output step before dropping the fraction bits.
  assign sum   = prod_q + (PW'(1) << (FRACTION_BITS - 1));
  assign rnd_d = sum[FRACTION_BITS +: fpa_pkg::WORD_W];

  // Product stage, then rounding stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(mag_a_i) * PW'(mag_b_i);
      rnd_q  <= rnd_d;
    end
  end

  assign mag_o = rnd_q;

endmodule

`default_nettype wire

@@ design/fpa_divider.sv @@
// ----------------------------------------------------------------------------
// Fixed-point divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_divider #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       en_i,
  input  wire logic [fpa_pkg::WORD_W-1:0]                 mag_a_i,
  input  wire logic [fpa_pkg::WORD_W-1:0]                 mag_b_i,
  output logic      [fpa_pkg::WORD_W+FRACTION_BITS-1:0]   quo_o,
  output logic      [fpa_pkg::WORD_W-1:0]                 rem_o,
  output logic      [fpa_pkg::WORD_W-1:0]                 den_o
);

  localparam int unsigned W  = fpa_pkg::WORD_W;
  localparam int unsigned NW = W + FRACTION_BITS;

  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [W-1:0]  rem_q [NW];
  logic [W-1:0]  den_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_src, quo_src;
    logic [W-1:0]  rem_src, den_src;
    logic [W:0]    trial;
    logic          ge;

    // Stage zero takes the scaled dividend; later stages chain.
    if (s == 0) begin : g_first
      assign num_src = {mag_a_i, FRACTION_BITS'(0)};
      assign quo_src = '0;
      assign rem_src = '0;
      assign den_src = mag_b_i;
    end else begin : g_next
      assign num_src = num_q[s-1];
      assign quo_src = quo_q[s-1];
      assign rem_src = rem_q[s-1];
      assign den_src = den_q[s-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign trial = {rem_src, num_src[NW-1]};
    assign ge    = trial >= {1'b0, den_src};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= {num_src[NW-2:0], 1'b0};
        quo_q[s] <= {quo_src[NW-2:0], ge};
        rem_q[s] <= ge ? W'(trial - {1'b0, den_src}) : trial[W-1:0];
        den_q[s] <= den_src;
      end
    end
  end

  assign quo_o = quo_q[NW-1];
  assign rem_o = rem_q[NW-1];
  assign den_o = den_q[NW-1];

endmodule

`default_nettype wire

@@ design/fixed_point_q24_8_alu.sv @@
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Signed fixed-point ALU with compare flags, rounded multiply and divide.
// ----------------------------------------------------------------------------
// Path: input register, prepare register, divider stages, then the result register.
// Throughput: one transaction per cycle when not stalled; one quotient bit per stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears only the valid bits; payload registers are not reset.
`default_nettype none

module fixed_point_q24_8_alu #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);

  localparam int unsigned W  = fpa_pkg::WORD_W;
  localparam int unsigned NW = W + FRACTION_BITS;
  localparam int unsigned MD = NW - 2;

  logic en;

  // Input register stage.
  logic                          vld_a_q;
  logic [fpa_pkg::ACTION_W-1:0]  act_a_q;
  logic signed [W-1:0]           a_q, b_q;

  // Prepare stage outputs.
  logic                          vld_b_q;
  logic [W-1:0]                  mag_a_q, mag_b_q;
  fpa_pkg::fpa_side_t            side_d, side_b_q;
  logic [W-1:0]                  ua, ub;

  // Side-band and multiplier delay lines.
  logic [NW-1:0]                 vld_s_q;
  fpa_pkg::fpa_side_t            side_q [NW];
  logic [W-1:0]                  mres_q [MD];
  logic [W-1:0]                  mul_mag;

  // Divider outputs.
  logic [NW-1:0]                 quo;
  logic [W-1:0]                  rem, den;

  // Final stage.
  fpa_pkg::fpa_side_t            side_f;
  logic [W-1:0]                  div_mag, ar_mag, ar_res, res_d;
  logic                          rnd_up;
  logic                          out_vld_q;
  logic [W-1:0]                  res_q;
  logic                          lt_q, eq_q, gt_q, dz_q;

  // The whole pipeline advances unless a result is waiting at a stalled output.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i) begin
    if (en) begin
      act_a_q <= in_i.action;
      a_q     <= in_i.operand_a;
      b_q     <= in_i.operand_b;
    end
  end

  // Prepare: magnitudes, flags and the results that need neither multiplier nor divider.
  assign ua = a_q;
  assign ub = b_q;

  always_comb begin
    side_d            = '0;
    side_d.action     = act_a_q;
    side_d.is_less    = a_q < b_q;
    side_d.is_equal   = a_q == b_q;
    side_d.is_greater = a_q > b_q;
    side_d.neg        = a_q[W-1] ^ b_q[W-1];
    side_d.dz         = (act_a_q == fpa_pkg::OP_DIV) && (b_q == '0);
    case (act_a_q)
      fpa_pkg::OP_ADD:      side_d.simple_res = ua + ub;
      fpa_pkg::OP_SUB:      side_d.simple_res = ua - ub;
      fpa_pkg::OP_MIN:      side_d.simple_res = (a_q <= b_q) ? ua : ub;
      fpa_pkg::OP_MAX:      side_d.simple_res = (a_q >= b_q) ? ua : ub;
      fpa_pkg::OP_INC:      side_d.simple_res = ua + W'(1);
      fpa_pkg::OP_DEC:      side_d.simple_res = ua - W'(1);
      fpa_pkg::OP_FROM_INT: side_d.simple_res = ua << FRACTION_BITS;
      fpa_pkg::OP_TO_INT:   side_d.simple_res = $unsigned(a_q >>> FRACTION_BITS);
      default:              side_d.simple_res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_a_q  <= a_q[W-1] ? (W'(0) - ua) : ua;
      mag_b_q  <= b_q[W-1] ? (W'(0) - ub) : ub;
      side_b_q <= side_d;
    end
  end

  fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_a_i (mag_a_q),
    .mag_b_i (mag_b_q),
    .mag_o   (mul_mag)
  );

  fpa_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_a_i (mag_a_q),
    .mag_b_i (mag_b_q),
    .quo_o   (quo),
    .rem_o   (rem),
    .den_o   (den)
  );

  // Delay lines that keep side-band data aligned with the divider.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_b_q;
      mres_q[0] <= mul_mag;
      for (int unsigned i = 1; i < NW; i++) side_q[i] <= side_q[i-1];
      for (int unsigned i = 1; i < MD; i++) mres_q[i] <= mres_q[i-1];
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_s_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_a_q   <= in_i.valid;
      vld_b_q   <= vld_a_q;
      vld_s_q   <= {vld_s_q[NW-2:0], vld_b_q};
      out_vld_q <= vld_s_q[NW-1];
    end
  end

  // Final: round the quotient, apply the sign and pick the result.
  assign side_f  = side_q[NW-1];
  assign rnd_up  = {rem, 1'b0} >= {1'b0, den};
  assign div_mag = quo[W-1:0] + W'(rnd_up);
  assign ar_mag  = (side_f.action == fpa_pkg::OP_MUL) ? mres_q[MD-1] : div_mag;
  assign ar_res  = side_f.neg ? (W'(0) - ar_mag) : ar_mag;

  always_comb begin
    case (side_f.action)
      fpa_pkg::OP_MUL: res_d = ar_res;
      fpa_pkg::OP_DIV: res_d = side_f.dz ? '0 : ar_res;
      default:         res_d = side_f.simple_res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      lt_q  <= side_f.is_less;
      eq_q  <= side_f.is_equal;
      gt_q  <= side_f.is_greater;
      dz_q  <= side_f.dz;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.result         = res_q;
  assign out_o.is_less        = lt_q;
  assign out_o.is_equal       = eq_q;
  assign out_o.is_greater     = gt_q;
  assign out_o.divide_by_zero = dz_q;

  // A result always carries exactly one comparison flag.
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot({lt_q, eq_q, gt_q}))
    else $error("compare flags not one-hot");

  // A division by zero always yields a zero result.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && dz_q) |-> (res_q == '0))
    else $error("divide by zero with nonzero result");

  // Input is refused only while a result waits at a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_vld_q && !out_o.ready))
    else $error("input stalled without output back-pressure");

  // A stalled pipeline keeps its last stage valid bit.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (vld_s_q[NW-1] == $past(vld_s_q[NW-1])))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations through the valid/ready input channel
// and checks every result against typed-in values or an internal predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WORD_W     = fpa_pkg::WORD_W;
  localparam int unsigned ACTION_W   = fpa_pkg::ACTION_W;
  localparam int unsigned FB         = fpa_pkg::FRACTION_BITS;
  localparam int          N_RANDOM   = 1700;
  localparam int          LATENCY    = WORD_W + FB + 2;
  localparam int          MAX_SHOWN  = 10;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              is_less;
    logic              is_equal;
    logic              is_greater;
    logic              divide_by_zero;
  } alu_result_t;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    bit                  typed;
    alu_result_t         res;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpa_in_if  op_ch ();
  fpa_out_if res_ch ();

  fixed_point_q24_8_alu dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch.sink),
    .out_o (res_ch.source)
  );

  alu_result_t pending_results[$];
  int          mismatch_count = 0;
  int          result_count   = 0;
  int          sent_count     = 0;
  bit          stimulus_done  = 1'b0;
  bit          hold_off_req   = 1'b0;
  bit          hold_off_done  = 1'b0;

  always #6 clk_i = ~clk_i;

  // Exact integer model of one ALU operation.
  function automatic alu_result_t alu_predict(logic [ACTION_W-1:0] action,
                                              logic [WORD_W-1:0] a_raw,
                                              logic [WORD_W-1:0] b_raw);
    alu_result_t    r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] mag;
    bit          neg;
    a = 64'(signed'(a_raw));
    b = 64'(signed'(b_raw));
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    r = '0;
    case (action)
      fpa_pkg::OP_ADD: r.result = a_raw + b_raw;
      fpa_pkg::OP_SUB: r.result = a_raw - b_raw;
      fpa_pkg::OP_MUL: begin
        mag = (ma * mb + (64'd1 << (FB - 1))) >> FB;
        r.result = neg ? -mag[WORD_W-1:0] : mag[WORD_W-1:0];
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          q = (ma << FB) / mb;
          rem = (ma << FB) - q * mb;
          if (2 * rem >= mb) q = q + 1;
          r.result = neg ? -q[WORD_W-1:0] : q[WORD_W-1:0];
        end
      end
      fpa_pkg::OP_MIN:      r.result = (a <= b) ? a_raw : b_raw;
      fpa_pkg::OP_MAX:      r.result = (a >= b) ? a_raw : b_raw;
      fpa_pkg::OP_INC:      r.result = a_raw + 1;
      fpa_pkg::OP_DEC:      r.result = a_raw - 1;
      fpa_pkg::OP_FROM_INT: r.result = a_raw << FB;
      fpa_pkg::OP_TO_INT:   r.result = WORD_W'(signed'(a_raw) >>> FB);
      default:              r.result = '0;
    endcase
    r.is_less    = a < b;
    r.is_equal   = a == b;
    r.is_greater = a > b;
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
           ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Offer one transaction and wait until it is taken.
  task automatic send_op(logic [ACTION_W-1:0] action, logic [WORD_W-1:0] a,
                         logic [WORD_W-1:0] b, alu_result_t expected);
    op_ch.valid     <= 1'b1;
    op_ch.action    <= action;
    op_ch.operand_a <= a;
    op_ch.operand_b <= b;
    do @(posedge clk_i); while (!op_ch.ready);
    pending_results.push_back(expected);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic idle_input(int cycles);
    if (cycles > 0) begin
      op_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  function automatic logic [WORD_W-1:0] random_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return WORD_W'(signed'($urandom_range(0, 4000)) - 2000);
      2: return WORD_W'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // Directed stimulus followed by random stimulus.
  initial begin
    directed_row_t rows[$];
    logic [ACTION_W-1:0] act;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    alu_result_t         exp_res;
    int                  wait_cycles;

    op_ch.valid     = 1'b0;
    op_ch.action    = '0;
    op_ch.operand_a = '0;
    op_ch.operand_b = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Rows with expected values typed in, then rows left to the predictor.
    rows.push_back('{fpa_pkg::OP_DIV, 32'd1000, 32'd0, 1,
                     '{32'd0, 1'b0, 1'b0, 1'b1, 1'b1}});
    rows.push_back('{fpa_pkg::OP_DIV, 32'd0, 32'd0, 1,
                     '{32'd0, 1'b0, 1'b1, 1'b0, 1'b1}});
    rows.push_back('{fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 1,
                     '{32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b0}});
    rows.push_back('{fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1, 1,
                     '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}});
    rows.push_back('{fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                     '{32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b0}});
    rows.push_back('{fpa_pkg::OP_DEC, 32'h8000_0000, 32'h8000_0000, 1,
                     '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0}});
    rows.push_back('{4'd10, 32'd5, 32'd7, 1, '{32'd0, 1'b1, 1'b0, 1'b0, 1'b0}});
    rows.push_back('{4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 1,
                     '{32'd0, 1'b0, 1'b0, 1'b1, 1'b0}});
    rows.push_back('{fpa_pkg::OP_MUL, 32'd384, 32'd384, 0, '0});   // exact product, no tie
    rows.push_back('{fpa_pkg::OP_MUL, -32'sd384, 32'd384, 0, '0});
    rows.push_back('{fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0});
    rows.push_back('{fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0});
    rows.push_back('{fpa_pkg::OP_DIV, 32'h8000_0000, -32'sd256, 0, '0});   // wraps
    rows.push_back('{fpa_pkg::OP_DIV, 32'd1, 32'd2, 0, '0});
    rows.push_back('{fpa_pkg::OP_DIV, -32'sd1, 32'd3, 0, '0});
    rows.push_back('{fpa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'd1, 0, '0});
    rows.push_back('{fpa_pkg::OP_MIN, -32'sd5, 32'd5, 0, '0});
    rows.push_back('{fpa_pkg::OP_MAX, -32'sd5, 32'd5, 0, '0});
    rows.push_back('{fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0});
    rows.push_back('{fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0});
    rows.push_back('{fpa_pkg::OP_FROM_INT, 32'h00FF_FFFF, 32'd0, 0, '0});
    rows.push_back('{fpa_pkg::OP_FROM_INT, 32'h8000_0001, 32'd0, 0, '0});
    rows.push_back('{fpa_pkg::OP_TO_INT, -32'sd1, 32'd0, 0, '0});
    rows.push_back('{fpa_pkg::OP_TO_INT, 32'h8000_0000, 32'd0, 0, '0});
    rows.push_back('{fpa_pkg::OP_TO_INT, 32'h7FFF_FFFF, 32'd0, 0, '0});
    foreach (rows[i]) begin
      exp_res = rows[i].typed ? rows[i].res :
                alu_predict(rows[i].action, rows[i].a, rows[i].b);
      send_op(rows[i].action, rows[i].a, rows[i].b, exp_res);
      idle_input(short_gap());
    end

    // Random operations; the receiver holds off partway, the sender drains once.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) hold_off_req = 1'b1;
      if (n == (2 * N_RANDOM) / 3) begin
        op_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk_i);
      end
      act = ($urandom_range(0, 15) == 0)
            ? 4'($urandom_range(10, 15))
            : 4'($urandom_range(fpa_pkg::OP_ADD, fpa_pkg::OP_TO_INT));
      a = random_operand();
      case ($urandom_range(0, 5))
        0: b = a;
        1: b = '0;
        2: b = a + 1;
        default: b = random_operand();
      endcase
      if (act == fpa_pkg::OP_DIV && b == 0 && $urandom_range(0, 3) != 0)
        b = random_operand();
      send_op(act, a, b, alu_predict(act, a, b));
      idle_input(short_gap());
    end
    op_ch.valid <= 1'b0;

    // Drain and let the pipeline settle.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(negedge clk_i);
    stimulus_done = 1'b1;
  end

  // Result side back-pressure, including one long hold-off.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (3 * LATENCY) @(negedge clk_i);
      end
      gap = short_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.result, res_ch.is_less, res_ch.is_equal, res_ch.is_greater,
              res_ch.divide_by_zero};
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("Unexpected result transaction: result=%h", got.result);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"Mismatch #%0d: expected res=%h lt=%b eq=%b gt=%b dz=%b,",
                      " got res=%h lt=%b eq=%b gt=%b dz=%b"},
                     result_count, want.result, want.is_less, want.is_equal,
                     want.is_greater, want.divide_by_zero, got.result, got.is_less,
                     got.is_equal, got.is_greater, got.divide_by_zero);
        end
      end
    end
  end

  // Final report.
  initial begin
    wait (stimulus_done);
    if (pending_results.size() != 0) mismatch_count += pending_results.size();
    $display("Sent %0d operations over all actions, unused codes and zero divisors;",
             sent_count);
    $display("checked %0d results with %0d mismatches.", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Timeout after %0d results.", result_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
